// File: hdl/pfdf_pkg.sv
package pfdf_pkg;

    // defaults for the top-level parameters
    localparam int SCREEN_WIDTH_DEF = 128;
    localparam int PAGE_COUNT_DEF   = 8;

    // fixed field widths
    localparam int OPCODE_W   = 3;
    localparam int COORD_W    = 8;
    localparam int SPAGE_W    = 3;
    localparam int SCOL_W     = 7;
    localparam int DPAGE_W    = 5;   // pixel_y >> 3
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 11;
    localparam int OFFSET_W   = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0]  THRESH_RESET = 11'd32;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 2'd2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_DRAW  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_BEGIN = 3'd2,
        OP_SCAN  = 3'd3,
        OP_END   = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 1'd0,
        CFG_OFFSET    = 1'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic accept;   // word taken this cycle
        logic commit;   // latched word takes effect this cycle
        logic sweep;    // zeroing pass step
    } t_ctl_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                blocked;     // scan has a byte but output is full and not ready
        logic                sweep_last;
    } t_dp_status;

endpackage

// File: hdl/pfdf_in_if.sv
interface pfdf_in_if;
    logic                            valid;
    logic                            ready;
    logic [pfdf_pkg::OPCODE_W-1:0]   opcode;
    logic [pfdf_pkg::COORD_W-1:0]    pixel_x;
    logic [pfdf_pkg::COORD_W-1:0]    pixel_y;
    logic                            pixel_on;
    logic [pfdf_pkg::SPAGE_W-1:0]    scan_page;
    logic [pfdf_pkg::SCOL_W-1:0]     scan_column;

    modport source (
        output valid, opcode, pixel_x, pixel_y, pixel_on, scan_page, scan_column,
        input  ready
    );
    modport sink (
        input  valid, opcode, pixel_x, pixel_y, pixel_on, scan_page, scan_column,
        output ready
    );
endinterface

// File: hdl/pfdf_out_if.sv
interface pfdf_out_if;
    logic                          valid;
    logic                          ready;
    logic [pfdf_pkg::SPAGE_W-1:0]  out_page;
    logic [pfdf_pkg::BYTE_W-1:0]   column_address;
    logic [pfdf_pkg::BYTE_W-1:0]   data_byte;
    logic                          run_start;

    modport source (
        output valid, out_page, column_address, data_byte, run_start,
        input  ready
    );
    modport sink (
        input  valid, out_page, column_address, data_byte, run_start,
        output ready
    );
endinterface

// File: hdl/pfdf_ram.sv
module pfdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/pfdf_ctrl.sv
module pfdf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  pfdf_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output pfdf_pkg::t_ctl_cmd    o_cmd
);
    pfdf_pkg::t_state r_state;
    pfdf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfdf_pkg::ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfdf_pkg::ST_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state = pfdf_pkg::ST_IDLE;
                end
            end
            pfdf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = pfdf_pkg::ST_EXEC;
                end
            end
            pfdf_pkg::ST_EXEC: begin
                if (!i_status.blocked) begin
                    if (i_status.op == pfdf_pkg::OP_CLEAR || i_status.op == pfdf_pkg::OP_END) begin
                        n_state = pfdf_pkg::ST_SWEEP;
                    end else begin
                        n_state = pfdf_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = pfdf_pkg::ST_SWEEP;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        o_cmd.sweep  = 1'b0;
        unique case (r_state)
            pfdf_pkg::ST_SWEEP: o_cmd.sweep = 1'b1;
            pfdf_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            pfdf_pkg::ST_EXEC: o_cmd.commit = !i_status.blocked;
            default: o_cmd.sweep = 1'b0;
        endcase
    end
endmodule

// File: hdl/pfdf_datapath.sv
module pfdf_datapath #(
    parameter int SCREEN_WIDTH = pfdf_pkg::SCREEN_WIDTH_DEF,
    parameter int PAGE_COUNT   = pfdf_pkg::PAGE_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pfdf_in_if.sink                             i_in,
    pfdf_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [pfdf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfdf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  pfdf_pkg::t_ctl_cmd                  i_cmd,
    output pfdf_pkg::t_dp_status                o_status
);
    localparam int ENTRIES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int AW      = $clog2(ENTRIES);
    localparam int PGW     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ROWS    = PAGE_COUNT * 8;
    localparam int IDX_W   = pfdf_pkg::DPAGE_W + 9;

    // latched word
    logic [pfdf_pkg::OPCODE_W-1:0] r_op;
    logic [pfdf_pkg::DPAGE_W-1:0]  r_page;
    logic [pfdf_pkg::COORD_W-1:0]  r_col;
    logic [2:0]                    r_bit;
    logic                          r_on;
    logic                          r_in_range;
    logic [AW-1:0]                 r_addr;

    // bookkeeping
    logic [pfdf_pkg::COUNT_W-1:0]  r_count,  n_count;
    logic [PAGE_COUNT-1:0]         r_changed, n_changed;
    logic                          r_cleared, n_cleared;
    logic                          r_full,    n_full;
    logic                          r_prior,   n_prior;
    logic [pfdf_pkg::COUNT_W-1:0]  r_thresh,  n_thresh;
    logic [pfdf_pkg::OFFSET_W-1:0] r_offset,  n_offset;
    logic                          r_sweep_frame, n_sweep_frame;
    logic [AW-1:0]                 r_sweep,   n_sweep;
    logic                          r_o_valid, n_o_valid;

    logic [pfdf_pkg::SPAGE_W-1:0]  r_o_page;
    logic [pfdf_pkg::BYTE_W-1:0]   r_o_col_addr;
    logic [pfdf_pkg::BYTE_W-1:0]   r_o_data;
    logic                          r_o_start;

    // accept-side address
    logic [pfdf_pkg::DPAGE_W-1:0]  a_page;
    logic [pfdf_pkg::COORD_W-1:0]  a_col;
    logic                          a_in_range;
    logic [IDX_W-1:0]              a_idx;

    // memory ports
    logic                          w_frame_we, w_dirty_we;
    logic [AW-1:0]                 w_waddr, w_raddr;
    logic [pfdf_pkg::BYTE_W-1:0]   w_frame_wdata, w_frame_rdata;
    logic                          w_dirty_wdata, w_dirty_rdata;

    logic [pfdf_pkg::BYTE_W-1:0]   w_mask, w_upd;
    logic                          w_is_draw, w_is_scan, w_draw_change, w_emit, w_load;
    logic                          w_page_bit;
    logic                          w_sweep_last;

    always_comb begin
        if (i_in.opcode == pfdf_pkg::OP_SCAN) begin
            a_page     = pfdf_pkg::DPAGE_W'(i_in.scan_page);
            a_col      = pfdf_pkg::COORD_W'(i_in.scan_column);
            a_in_range = (pfdf_pkg::DPAGE_W'(i_in.scan_page) < pfdf_pkg::DPAGE_W'(PAGE_COUNT))
                      && (9'(i_in.scan_column) < 9'(SCREEN_WIDTH));
        end else begin
            a_page     = i_in.pixel_y[7:3];
            a_col      = i_in.pixel_x;
            a_in_range = (9'(i_in.pixel_x) < 9'(SCREEN_WIDTH))
                      && (9'(i_in.pixel_y) < 9'(ROWS));
        end
        a_idx = IDX_W'(a_page) * IDX_W'(SCREEN_WIDTH) + IDX_W'(a_col);
    end

    pfdf_ram #(.WIDTH(pfdf_pkg::BYTE_W), .DEPTH(ENTRIES)) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_frame_we),
        .i_waddr (w_waddr),
        .i_wdata (w_frame_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_frame_rdata)
    );

    pfdf_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_dirty (
        .i_clk   (i_clk),
        .i_we    (w_dirty_we),
        .i_waddr (w_waddr),
        .i_wdata (w_dirty_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_dirty_rdata)
    );

    // read the accepted word's entry now, hold that address while executing
    assign w_raddr = i_cmd.accept ? a_idx[AW-1:0] : r_addr;

    assign w_is_draw     = (r_op == pfdf_pkg::OP_DRAW) && r_in_range;
    assign w_is_scan     = (r_op == pfdf_pkg::OP_SCAN) && r_in_range;
    assign w_mask        = pfdf_pkg::BYTE_W'(1) << r_bit;
    assign w_upd         = r_on ? (w_frame_rdata | w_mask) : (w_frame_rdata & ~w_mask);
    assign w_draw_change = w_is_draw && (w_upd != w_frame_rdata);
    assign w_page_bit    = r_changed[r_page[PGW-1:0]];
    assign w_emit        = r_full || (w_dirty_rdata && w_page_bit);
    assign w_load        = i_cmd.commit && w_is_scan && w_emit;
    assign w_sweep_last  = (r_sweep == AW'(ENTRIES - 1));

    always_comb begin
        w_waddr       = i_cmd.sweep ? r_sweep : r_addr;
        w_frame_we    = (i_cmd.sweep && r_sweep_frame) || (i_cmd.commit && w_draw_change);
        w_frame_wdata = i_cmd.sweep ? '0 : w_upd;
        w_dirty_we    = i_cmd.sweep
                     || (i_cmd.commit && w_draw_change && !w_dirty_rdata)
                     || w_load;
        w_dirty_wdata = !i_cmd.sweep && (r_op == pfdf_pkg::OP_DRAW);
    end

    always_comb begin
        n_count       = r_count;
        n_changed     = r_changed;
        n_cleared     = r_cleared;
        n_full        = r_full;
        n_prior       = r_prior;
        n_thresh      = r_thresh;
        n_offset      = r_offset;
        n_sweep_frame = r_sweep_frame;
        n_sweep       = r_sweep;
        n_o_valid     = r_o_valid && !o_out.ready;

        if (i_cmd.sweep) begin
            n_sweep = w_sweep_last ? '0 : r_sweep + AW'(1);
        end

        if (i_cmd.commit) begin
            unique case (r_op)
                pfdf_pkg::OP_DRAW: begin
                    // a newly dirty entry counts once
                    if (w_draw_change && !w_dirty_rdata) begin
                        n_changed = r_changed | (PAGE_COUNT'(1) << r_page[PGW-1:0]);
                        if (r_count != pfdf_pkg::COUNT_MAX) begin
                            n_count = r_count + pfdf_pkg::COUNT_W'(1);
                        end
                    end
                end
                pfdf_pkg::OP_CLEAR: begin
                    n_count       = '0;
                    n_changed     = '0;
                    n_cleared     = 1'b1;
                    n_sweep_frame = 1'b1;
                end
                pfdf_pkg::OP_BEGIN: begin
                    n_full = r_cleared || (r_count > r_thresh);
                end
                pfdf_pkg::OP_SCAN: begin
                    n_prior = w_is_scan && w_emit;
                    if (w_load) begin
                        n_o_valid = 1'b1;
                    end
                end
                pfdf_pkg::OP_END: begin
                    n_count       = '0;
                    n_changed     = '0;
                    n_prior       = 1'b0;
                    n_full        = 1'b0;
                    n_sweep_frame = 1'b0;
                    if (r_full) begin
                        n_cleared = 1'b0;
                    end
                end
                default: n_full = r_full;
            endcase
        end

        if (i_cfg_we) begin
            unique case (pfdf_pkg::t_cfg_index'(i_cfg_index))
                pfdf_pkg::CFG_THRESHOLD: n_thresh = i_cfg_data;
                pfdf_pkg::CFG_OFFSET:    n_offset = i_cfg_data[pfdf_pkg::OFFSET_W-1:0];
                default:                 n_thresh = r_thresh;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_changed     <= '0;
            r_cleared     <= 1'b1;
            r_full        <= 1'b0;
            r_prior       <= 1'b0;
            r_thresh      <= pfdf_pkg::THRESH_RESET;
            r_offset      <= pfdf_pkg::OFFSET_RESET;
            r_sweep_frame <= 1'b1;
            r_sweep       <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_count       <= n_count;
            r_changed     <= n_changed;
            r_cleared     <= n_cleared;
            r_full        <= n_full;
            r_prior       <= n_prior;
            r_thresh      <= n_thresh;
            r_offset      <= n_offset;
            r_sweep_frame <= n_sweep_frame;
            r_sweep       <= n_sweep;
            r_o_valid     <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_in.opcode;
            r_page     <= a_page;
            r_col      <= a_col;
            r_bit      <= i_in.pixel_y[2:0];
            r_on       <= i_in.pixel_on;
            r_in_range <= a_in_range;
            r_addr     <= a_idx[AW-1:0];
        end
        if (w_load) begin
            r_o_page     <= r_page[pfdf_pkg::SPAGE_W-1:0];
            r_o_col_addr <= r_col + pfdf_pkg::BYTE_W'(r_offset);
            r_o_data     <= w_frame_rdata;
            r_o_start    <= (r_col == '0) || !r_prior;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.out_page       = r_o_page;
    assign o_out.column_address = r_o_col_addr;
    assign o_out.data_byte      = r_o_data;
    assign o_out.run_start      = r_o_start;

    assign o_status.op         = r_op;
    assign o_status.blocked    = w_is_scan && w_emit && r_o_valid && !o_out.ready;
    assign o_status.sweep_last = w_sweep_last;
endmodule

// File: hdl/page_framebuffer_dirty_flush_top.sv
// channel   | dir | handshake     | word
// i_in      | in  | valid/ready   | opcode, pixel_x, pixel_y, pixel_on, scan_page, scan_column
// o_out     | out | valid/ready   | out_page, column_address, data_byte, run_start
// i_cfg_*   | in  | write enable  | index 0 threshold, 1 column offset
//
// Draw, begin flush, scan and unknown ops: accept plus the registered frame/dirty
// RAM read, then the read-modify-write. Clear frame and end flush add a zeroing
// pass over the SCREEN_WIDTH*PAGE_COUNT entries (1024 by default) of the dirty RAM,
// clear also of the frame RAM; reset starts with the clear pass, i_in.ready low.
// A scan that has a byte holds in execute while the output register is full and o_out.ready is low.
module page_framebuffer_dirty_flush_top #(
    parameter int SCREEN_WIDTH = pfdf_pkg::SCREEN_WIDTH_DEF,
    parameter int PAGE_COUNT   = pfdf_pkg::PAGE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pfdf_in_if.sink                         i_in,
    pfdf_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [pfdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfdf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    pfdf_pkg::t_ctl_cmd   w_cmd;
    pfdf_pkg::t_dp_status w_status;
    logic                 w_ready;

    pfdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_in_ready (w_ready),
        .o_cmd      (w_cmd)
    );

    pfdf_datapath #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .PAGE_COUNT   (PAGE_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

    assign i_in.ready = w_ready;
endmodule
